### src/duration_text_to_ms_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the duration text converter
// Shared property forms, clocked on clock; the first two are disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef DURATION_TEXT_TO_MS_MACROS_SVH
`define DURATION_TEXT_TO_MS_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define DTMS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("duration_text_to_ms check failed");

// Next-cycle implication, ignored while reset is high.
`define DTMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("duration_text_to_ms check failed");

// Next-cycle implication that also holds through reset.
`define DTMS_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("duration_text_to_ms check failed");

`endif

### src/dtms_pkg.sv
// ---------------------------------------------------------------------------
// dtms_pkg
// Types, constants and unit tables shared by the duration converter.
// ---------------------------------------------------------------------------
package dtms_pkg;

   localparam int FRACTION_DIGITS = 6;
   localparam int MS_W    = 61;
   localparam int MANT_W  = 62;
   localparam int FRAC_W  = $clog2(10 ** FRACTION_DIGITS);
   localparam int FDIG_W  = $clog2(FRACTION_DIGITS + 1);
   localparam int SCALE_W = 35;
   localparam int FPROD_W = FRAC_W + SCALE_W;
   localparam int DIV_W   = FRAC_W + 1;
   localparam int STEP_W  = $clog2(FPROD_W + 1);
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [MS_W-1:0]   MAX_MS        = '1;
   localparam logic [MANT_W-1:0] INT_CAP       = {1'b1, {(MANT_W-1){1'b0}}};
   localparam logic [MANT_W-1:0] INT_CAP_DIV10 = INT_CAP / 10;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_NUMBER,
      PH_UNIT,
      PH_IGNORE
   } phase_type;

   typedef enum logic [3:0] {
      UNIT_NONE,
      UNIT_MS,
      UNIT_SEC,
      UNIT_MIN,
      UNIT_HOUR,
      UNIT_DAY,
      UNIT_WEEK,
      UNIT_MONTH,
      UNIT_YEAR
   } unit_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_TERM,
      BK_SUM,
      BK_OUT
   } back_state_type;

   // One queue entry: a term to convert and/or the end-of-text marker.
   typedef struct packed {
      logic                has_term;
      logic                is_end;
      logic                bad;
      logic [MANT_W-1:0]   mant;
      logic [FRAC_W-1:0]   frac;
      logic [FDIG_W-1:0]   fdig;
      unit_type            unit;
   } term_type;

   typedef struct packed {
      logic has_item;
      logic has_room;
   } q_status_type;

   // Letter 0 sits in bits 39:32 of the word.
   function automatic unit_type unit_decode(input logic [39:0] word,
                                            input logic [2:0]  len,
                                            input logic        too_long);
      unit_type u;
      u = UNIT_NONE;
      if (!too_long) begin
         case (len)
            3'd0: u = UNIT_SEC;
            3'd1: begin
               case (word[39:32])
                  "s":     u = UNIT_SEC;
                  "m":     u = UNIT_MIN;
                  "h":     u = UNIT_HOUR;
                  "d":     u = UNIT_DAY;
                  "w":     u = UNIT_WEEK;
                  "y":     u = UNIT_YEAR;
                  default: u = UNIT_NONE;
               endcase
            end
            3'd2: begin
               case (word[39:24])
                  "ms":    u = UNIT_MS;
                  "hr":    u = UNIT_HOUR;
                  "wk":    u = UNIT_WEEK;
                  "mo":    u = UNIT_MONTH;
                  "yr":    u = UNIT_YEAR;
                  default: u = UNIT_NONE;
               endcase
            end
            3'd3: begin
               case (word[39:16])
                  "sec":   u = UNIT_SEC;
                  "min":   u = UNIT_MIN;
                  "day":   u = UNIT_DAY;
                  "mon":   u = UNIT_MONTH;
                  default: u = UNIT_NONE;
               endcase
            end
            3'd4: begin
               case (word[39:8])
                  "hour":  u = UNIT_HOUR;
                  "week":  u = UNIT_WEEK;
                  "year":  u = UNIT_YEAR;
                  default: u = UNIT_NONE;
               endcase
            end
            3'd5: begin
               if (word == "month") begin
                  u = UNIT_MONTH;
               end
            end
            default: u = UNIT_NONE;
         endcase
      end
      return u;
   endfunction

   function automatic logic [SCALE_W-1:0] unit_scale(input unit_type u);
      logic [SCALE_W-1:0] s;
      case (u)
         UNIT_MS:    s = SCALE_W'(1);
         UNIT_SEC:   s = SCALE_W'(1000);
         UNIT_MIN:   s = SCALE_W'(60000);
         UNIT_HOUR:  s = SCALE_W'(3600000);
         UNIT_DAY:   s = SCALE_W'(86400000);
         UNIT_WEEK:  s = SCALE_W'(604800000);
         UNIT_MONTH: s = 35'd2592000000;
         UNIT_YEAR:  s = 35'd31536000000;
         default:    s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [FRAC_W-1:0] pow10(input logic [FDIG_W-1:0] n);
      logic [FRAC_W-1:0] p;
      p = FRAC_W'(1);
      for (int k = 0; k < FRACTION_DIGITS; k++) begin
         if (k < int'(n)) begin
            p = (p << 3) + (p << 1);
         end
      end
      return p;
   endfunction

endpackage

### src/dtms_front.sv
// ---------------------------------------------------------------------------
// dtms_front
// Character parser: tracks the number and unit of each term and queues terms.
// ---------------------------------------------------------------------------
module dtms_front import dtms_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_char_code,
   input  logic         req_last_char,
   input  q_status_type q_status,
   output logic         push0,
   output term_type     entry0,
   output logic         push1,
   output term_type     entry1
);

   phase_type           phase_ff, phase_in;
   logic [MANT_W-1:0]   mant_ff, mant_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic [FDIG_W-1:0]   fdig_ff, fdig_in;
   logic                dot_ff, dot_in;
   logic                dig_ff, dig_in;
   logic [39:0]         letters_ff, letters_in;
   logic [2:0]          ulen_ff, ulen_in;
   logic                ulong_ff, ulong_in;
   logic                bad_ff, bad_in;

   logic                accept;
   logic                is_digit, is_dot, is_letter, is_blank;
   logic [3:0]          digit;

   function automatic logic [MANT_W-1:0] mant_step(input logic [MANT_W-1:0] m,
                                                   input logic [3:0] d);
      logic [MANT_W+1:0] w;
      w = ({2'b00, m} << 3) + ({2'b00, m} << 1) + (MANT_W+2)'(d);
      if (m > INT_CAP_DIV10 || w > {2'b00, INT_CAP}) begin
         return INT_CAP;
      end
      return w[MANT_W-1:0];
   endfunction

   assign req_stall = !q_status.has_room;
   assign accept    = req_valid && !req_stall;
   assign is_digit  = req_char_code inside {["0":"9"]};
   assign is_dot    = req_char_code == ".";
   assign is_letter = req_char_code inside {["a":"z"], ["A":"Z"]};
   assign is_blank  = req_char_code inside {8'h20, [8'h09:8'h0D]};
   assign digit     = req_char_code[3:0];

   always_comb begin
      logic     consumed;
      term_type term_a, term_e;
      logic     a_ok;
      consumed = 1'b0;
      a_ok     = 1'b0;
      term_a   = '0;
      term_e   = '0;
      phase_in   = phase_ff;
      mant_in    = mant_ff;
      frac_in    = frac_ff;
      fdig_in    = fdig_ff;
      dot_in     = dot_ff;
      dig_in     = dig_ff;
      letters_in = letters_ff;
      ulen_in    = ulen_ff;
      ulong_in   = ulong_ff;
      bad_in     = bad_ff;

      if (phase_in == PH_NUMBER) begin
         if (is_digit) begin
            consumed = 1'b1;
            dig_in   = 1'b1;
            if (!dot_in) begin
               mant_in = mant_step(mant_in, digit);
            end else if (fdig_in < FDIG_W'(FRACTION_DIGITS)) begin
               frac_in = (frac_in << 3) + (frac_in << 1) + FRAC_W'(digit);
               fdig_in = fdig_in + 1'b1;
            end
         end else if (is_dot && !dot_in) begin
            consumed = 1'b1;
            dot_in   = 1'b1;
         end else if (!dig_in) begin
            consumed = 1'b1;
            bad_in   = 1'b1;
            phase_in = PH_IGNORE;
         end else begin
            phase_in = PH_UNIT;
            ulen_in  = 3'd0;
            ulong_in = 1'b0;
         end
      end

      if (!consumed && phase_in == PH_UNIT) begin
         if (is_letter) begin
            consumed = 1'b1;
            if (ulen_in < 3'd5) begin
               for (int k = 0; k < 5; k++) begin
                  if (ulen_in == 3'(k)) begin
                     letters_in[39-8*k -: 8] = req_char_code | 8'h20;
                  end
               end
               ulen_in = ulen_in + 3'd1;
            end else begin
               ulong_in = 1'b1;
            end
         end else begin
            term_a.has_term = 1'b1;
            term_a.mant     = mant_in;
            term_a.frac     = frac_in;
            term_a.fdig     = fdig_in;
            term_a.unit     = unit_decode(letters_in, ulen_in, ulong_in);
            a_ok            = term_a.unit != UNIT_NONE;
            phase_in        = PH_SPACE;
         end
      end

      if (!consumed && phase_in == PH_SPACE) begin
         if (is_digit || is_dot) begin
            phase_in = PH_NUMBER;
            frac_in  = '0;
            fdig_in  = '0;
            dot_in   = is_dot;
            dig_in   = is_digit;
            mant_in  = is_digit ? MANT_W'(digit) : '0;
         end else if (!is_blank) begin
            phase_in = PH_IGNORE;
         end
      end

      if (req_last_char) begin
         if (phase_in == PH_NUMBER) begin
            if (!dig_in) begin
               bad_in   = 1'b1;
               phase_in = PH_IGNORE;
            end else begin
               phase_in = PH_UNIT;
               ulen_in  = 3'd0;
               ulong_in = 1'b0;
            end
         end
         term_e.is_end = 1'b1;
         term_e.bad    = bad_in;
         if (phase_in == PH_UNIT) begin
            term_e.mant     = mant_in;
            term_e.frac     = frac_in;
            term_e.fdig     = fdig_in;
            term_e.unit     = unit_decode(letters_in, ulen_in, ulong_in);
            term_e.has_term = term_e.unit != UNIT_NONE;
         end
         phase_in = PH_SPACE;
         mant_in  = '0;
         frac_in  = '0;
         fdig_in  = '0;
         dot_in   = 1'b0;
         dig_in   = 1'b0;
         ulen_in  = 3'd0;
         ulong_in = 1'b0;
         bad_in   = 1'b0;
      end

      push0  = 1'b0;
      push1  = 1'b0;
      entry0 = term_a;
      entry1 = term_e;
      if (accept) begin
         if (a_ok) begin
            push0 = 1'b1;
            push1 = req_last_char;
         end else if (req_last_char) begin
            push0  = 1'b1;
            entry0 = term_e;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         mant_ff  <= '0;
         frac_ff  <= '0;
         fdig_ff  <= '0;
         dot_ff   <= 1'b0;
         dig_ff   <= 1'b0;
         ulen_ff  <= 3'd0;
         ulong_ff <= 1'b0;
         bad_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         mant_ff  <= mant_in;
         frac_ff  <= frac_in;
         fdig_ff  <= fdig_in;
         dot_ff   <= dot_in;
         dig_ff   <= dig_in;
         ulen_ff  <= ulen_in;
         ulong_ff <= ulong_in;
         bad_ff   <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         letters_ff <= letters_in;
      end
   end

endmodule

### src/dtms_queue.sv
// ---------------------------------------------------------------------------
// dtms_queue
// Short term queue between parser and converter; takes up to two per cycle.
// ---------------------------------------------------------------------------
module dtms_queue import dtms_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push0,
   input  term_type     entry0,
   input  logic         push1,
   input  term_type     entry1,
   input  logic         pop,
   output term_type     head,
   output q_status_type q_status
);

   term_type            slots_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign head              = slots_ff[rd_ff];
   assign q_status.has_item = cnt_ff != '0;
   assign q_status.has_room = cnt_ff <= QCNT_W'(QDEPTH - 2);

   assign wr_in  = wr_ff + QPTR_W'(push0) + QPTR_W'(push1);
   assign rd_in  = rd_ff + QPTR_W'(pop);
   assign cnt_in = cnt_ff + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         slots_ff[wr_ff] <= entry0;
      end
      if (push1) begin
         slots_ff[wr_ff + QPTR_W'(1)] <= entry1;
      end
   end

endmodule

### src/dtms_back.sv
// ---------------------------------------------------------------------------
// dtms_back
// Term converter: serial multiply, serial divide, saturating sum, result beat.
// ---------------------------------------------------------------------------
module dtms_back import dtms_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  term_type        head,
   input  q_status_type    q_status,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [MS_W-1:0] rsp_total_ms,
   output logic            rsp_malformed,
   output logic            rsp_saturated
);

   back_state_type                state_ff, state_in;
   term_type                      ent_ff;
   logic [63:0]                   acc_ff;
   logic [FPROD_W-1:0]            facc_ff;
   logic [SCALE_W-1:0]            scale_ff;
   logic [STEP_W-1:0]             step_ff;
   logic [DIV_W+FPROD_W-1:0]      div_ff;
   logic [FRAC_W-1:0]             divisor_ff;
   logic [MS_W-1:0]               term_ff;
   logic [MS_W-1:0]               total_ff;
   logic                          sat_ff;
   logic                          rsp_valid_ff;
   logic [MS_W-1:0]               rsp_total_ff;
   logic                          rsp_bad_ff;
   logic                          rsp_sat_ff;

   logic                          load_rsp;
   logic [63:0]                   acc_next;
   logic [DIV_W+FPROD_W-1:0]      div_shift, div_next;
   logic [DIV_W-1:0]              div_top;
   logic [63:0]                   term_sum;
   logic [MS_W:0]                 total_sum;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_total_ms  = rsp_total_ff;
   assign rsp_malformed = rsp_bad_ff;
   assign rsp_saturated = rsp_sat_ff;

   always_comb begin
      acc_next = (acc_ff << 1) + (scale_ff[SCALE_W-1] ? {2'b00, ent_ff.mant} : 64'd0);
      if (acc_next > {3'b000, MAX_MS}) begin
         acc_next = {2'b00, INT_CAP};
      end
      div_shift = div_ff << 1;
      div_top   = div_shift[DIV_W+FPROD_W-1 -: DIV_W];
      div_next  = div_shift;
      if (div_top >= {1'b0, divisor_ff}) begin
         div_next[DIV_W+FPROD_W-1 -: DIV_W] = div_top - {1'b0, divisor_ff};
         div_next[0] = 1'b1;
      end
      term_sum  = acc_ff + 64'(div_ff[FPROD_W-1:0]);
      total_sum = {1'b0, total_ff} + {1'b0, term_ff};
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_status.has_item) begin
               pop = 1'b1;
               if (head.has_term) begin
                  state_in = BK_MUL;
               end else if (head.is_end) begin
                  state_in = BK_OUT;
               end
            end
         end
         BK_MUL: begin
            if (step_ff == STEP_W'(SCALE_W - 1)) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (step_ff == STEP_W'(FPROD_W - 1)) begin
               state_in = BK_TERM;
            end
         end
         BK_TERM: state_in = BK_SUM;
         BK_SUM:  state_in = ent_ff.is_end ? BK_OUT : BK_IDLE;
         BK_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            ent_ff   <= head;
            acc_ff   <= '0;
            facc_ff  <= '0;
            scale_ff <= unit_scale(head.unit);
            step_ff  <= '0;
         end
         BK_MUL: begin
            acc_ff   <= acc_next;
            facc_ff  <= (facc_ff << 1) +
                        (scale_ff[SCALE_W-1] ? FPROD_W'(ent_ff.frac) : '0);
            scale_ff <= scale_ff << 1;
            if (step_ff == STEP_W'(SCALE_W - 1)) begin
               step_ff    <= '0;
               divisor_ff <= pow10(ent_ff.fdig);
               div_ff     <= {{DIV_W{1'b0}}, (facc_ff << 1) +
                             (scale_ff[SCALE_W-1] ? FPROD_W'(ent_ff.frac) : '0)};
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
         BK_DIV: begin
            div_ff  <= div_next;
            step_ff <= step_ff + 1'b1;
         end
         BK_TERM: begin
            if (acc_ff > {3'b000, MAX_MS} || term_sum > {3'b000, MAX_MS}) begin
               term_ff <= MAX_MS;
            end else begin
               term_ff <= term_sum[MS_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Running sum and its saturation flag are cleared by reset and per result.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         sat_ff   <= 1'b0;
      end else if (load_rsp) begin
         total_ff <= '0;
         sat_ff   <= 1'b0;
      end else if (state_ff == BK_TERM) begin
         if (acc_ff > {3'b000, MAX_MS} || term_sum > {3'b000, MAX_MS}) begin
            sat_ff <= 1'b1;
         end
      end else if (state_ff == BK_SUM) begin
         if (total_sum > {1'b0, MAX_MS}) begin
            total_ff <= MAX_MS;
            sat_ff   <= 1'b1;
         end else begin
            total_ff <= total_sum[MS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_bad_ff   <= ent_ff.bad;
         rsp_total_ff <= ent_ff.bad ? '0 : total_ff;
         rsp_sat_ff   <= ent_ff.bad ? 1'b0 : sat_ff;
      end
   end

endmodule

### src/duration_text_to_ms.sv
// Flow: a term passes the converter's multiply steps, divide steps, term and
// sum states in order; the result beat is then registered in the output state.
// Throughput: one text byte per cycle while the term queue has two free slots;
// the single serial multiply-divide unit finishes each term before the next.
// Reset: synchronous, active high; clears parser, queue, sum and result valid.
// ---------------------------------------------------------------------------
// duration_text_to_ms
// Converts duration text such as 1h20m30s into milliseconds, one byte a beat.
// ---------------------------------------------------------------------------
module duration_text_to_ms import dtms_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_char_code,
   input  logic            req_last_char,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [MS_W-1:0] rsp_total_ms,
   output logic            rsp_malformed,
   output logic            rsp_saturated
);

   // The parser sees each input beat once. It keeps the number being read
   // (integer part capped just above the maximum, and up to six fraction
   // digits in exact decimal) together with up to five lower-cased unit
   // letters. When a term ends it is decoded to a unit code and pushed.
   // On the last byte an end marker is pushed too, carrying the lone-dot flag;
   // one byte can therefore push two entries, so the parser stalls its input
   // unless two slots are free.

   q_status_type q_status;
   logic         push0, push1, pop;
   term_type     entry0, entry1, head;

   dtms_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_status      (q_status),
      .push0         (push0),
      .entry0        (entry0),
      .push1         (push1),
      .entry1        (entry1)
   );

   // The queue lets the parser run ahead of the slow converter, so that a
   // host typing characters is rarely held off.
   dtms_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push0    (push0),
      .entry0   (entry0),
      .push1    (push1),
      .entry1   (entry1),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // The converter multiplies the integer part and the fraction by the unit
   // scale bit by bit, divides the fraction product by the power of ten
   // bit by bit, and adds the saturated term into the running sum. The result
   // beat sits in an output register, so a stalled result does not block the
   // parser from taking the next text.
   dtms_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_total_ms  (rsp_total_ms),
      .rsp_malformed (rsp_malformed),
      .rsp_saturated (rsp_saturated)
   );

endmodule

### src/duration_text_to_ms_checker.sv
// ---------------------------------------------------------------------------
// duration_text_to_ms_checker
// Port-level checks on the result channel of the duration converter.
// ---------------------------------------------------------------------------
`include "duration_text_to_ms_macros.svh"

module duration_text_to_ms_checker import dtms_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input logic [MS_W-1:0] rsp_total_ms,
   input logic            rsp_malformed,
   input logic            rsp_saturated
);

   `DTMS_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_total_ms))
   `DTMS_ASSERT_NOW(a_malformed_zero, rsp_valid && rsp_malformed, rsp_total_ms == '0 && !rsp_saturated)
   `DTMS_ASSERT_ALWAYS_NEXT(a_reset_quiet, reset, !rsp_valid && !req_stall)

endmodule

bind duration_text_to_ms duration_text_to_ms_checker u_checker (.*);

### dv/tb_duration_text_to_ms.sv
// ---------------------------------------------------------------------------
// tb_duration_text_to_ms
// Self-checking bench for the duration text converter. Texts are sent one
// byte a beat; a local parser predicts each total, and every result beat is
// compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_duration_text_to_ms;
   import dtms_pkg::*;

   localparam logic [63:0] MAX_TOTAL  = 64'h1FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MANT_LIMIT = 64'h2000_0000_0000_0000;
   localparam int          KEEP_FRAC  = 6;
   localparam longint      CYCLE_LIMIT = 64'd3_000_000;

   typedef struct packed {
      logic [MS_W-1:0] total;
      logic            malformed;
      logic            saturated;
   } duration_result_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [7:0]      req_char_code = 8'h00;
   logic            req_last_char = 1'b0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic [MS_W-1:0] rsp_total_ms;
   logic            rsp_malformed;
   logic            rsp_saturated;

   duration_text_to_ms dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle percentages for the sender and the receiver; changed per phase.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   duration_result_type expected_totals[$];
   int  mismatch_count = 0;
   int  bytes_sent = 0;
   int  texts_sent = 0;
   int  results_seen = 0;
   longint cycle_count = 0;

   // Predictor state, mirroring the parser's registers.
   phase_type   p_phase;
   logic [63:0] p_mant;
   logic [31:0] p_frac;
   int          p_fdig;
   logic        p_dot, p_digit;
   logic [7:0]  p_letters[5];
   int          p_ulen;
   logic        p_too_long, p_sat, p_bad;
   logic [63:0] p_total;

   function automatic void predictor_clear();
      p_phase = PH_SPACE;
      p_mant = '0;
      p_frac = '0;
      p_fdig = 0;
      p_dot = 1'b0;
      p_digit = 1'b0;
      foreach (p_letters[k]) p_letters[k] = 8'h00;
      p_ulen = 0;
      p_too_long = 1'b0;
      p_total = '0;
      p_sat = 1'b0;
      p_bad = 1'b0;
   endfunction

   function automatic logic is_digit_byte(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter_byte(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic void absorb_digit(logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - "0");
      p_digit = 1'b1;
      if (!p_dot) begin
         if (p_mant > MANT_LIMIT / 10) begin
            p_mant = MANT_LIMIT;
         end else begin
            p_mant = p_mant * 10 + d;
            if (p_mant > MANT_LIMIT) p_mant = MANT_LIMIT;
         end
      end else if (p_fdig < KEEP_FRAC) begin
         p_frac = p_frac * 10 + 32'(d);
         p_fdig++;
      end
   endfunction

   // Milliseconds per unit for the letters collected; zero for no match.
   function automatic logic [63:0] ms_per_unit();
      string w;
      w = "";
      if (p_too_long) return 0;
      for (int k = 0; k < p_ulen; k++) w = {w, string'(p_letters[k])};
      case (w)
         "ms":                 return 64'd1;
         "", "s", "sec":       return 64'd1000;
         "m", "min":           return 64'd60000;
         "h", "hr", "hour":    return 64'd3600000;
         "d", "day":           return 64'd86400000;
         "w", "wk", "week":    return 64'd604800000;
         "mo", "mon", "month": return 64'd2592000000;
         "y", "yr", "year":    return 64'd31536000000;
         default:              return 64'd0;
      endcase
   endfunction

   function automatic void close_number();
      if (!p_digit) begin
         p_bad = 1'b1;
         p_phase = PH_IGNORE;
      end else begin
         p_phase = PH_UNIT;
         p_ulen = 0;
         p_too_long = 1'b0;
      end
   endfunction

   // Adds the finished term to the sum, both clamped at the maximum.
   function automatic void close_term();
      logic [63:0] u, term, p10, frac_ms;
      u = ms_per_unit();
      if (u == 0) return;
      p10 = 1;
      for (int k = 0; k < p_fdig; k++) p10 = p10 * 10;
      if (p_mant > MAX_TOTAL / u) begin
         term = MAX_TOTAL;
         p_sat = 1'b1;
      end else begin
         frac_ms = 64'(p_frac) * (u / p10) + (64'(p_frac) * (u % p10)) / p10;
         term = p_mant * u + frac_ms;
         if (term > MAX_TOTAL) begin
            term = MAX_TOTAL;
            p_sat = 1'b1;
         end
      end
      if (term == 0) return;
      if (p_total > MAX_TOTAL - term) begin
         p_total = MAX_TOTAL;
         p_sat = 1'b1;
      end else begin
         p_total = p_total + term;
      end
   endfunction

   function automatic void parse_byte(logic [7:0] c);
      if (p_phase == PH_NUMBER) begin
         if (is_digit_byte(c)) begin
            absorb_digit(c);
            return;
         end
         if (c == "." && !p_dot) begin
            p_dot = 1'b1;
            return;
         end
         close_number();
         if (p_phase == PH_IGNORE) return;
      end
      if (p_phase == PH_UNIT) begin
         if (is_letter_byte(c)) begin
            if (p_ulen < 5) begin
               p_letters[p_ulen] = c | 8'h20;
               p_ulen++;
            end else begin
               p_too_long = 1'b1;
            end
            return;
         end
         close_term();
         p_phase = PH_SPACE;
      end
      if (p_phase == PH_SPACE) begin
         if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
         if (is_digit_byte(c) || c == ".") begin
            p_phase = PH_NUMBER;
            p_mant = '0;
            p_frac = '0;
            p_fdig = 0;
            p_dot = 1'b0;
            p_digit = 1'b0;
            if (c == ".") p_dot = 1'b1;
            else absorb_digit(c);
         end else begin
            p_phase = PH_IGNORE;
         end
      end
   endfunction

   // Feeds one accepted byte to the predictor; on the last byte the
   // predicted result is queued and the predictor returns to its reset state.
   function automatic void predict_byte(logic [7:0] c, logic last);
      duration_result_type r;
      parse_byte(c);
      if (!last) return;
      if (p_phase == PH_NUMBER) close_number();
      if (p_phase == PH_UNIT) close_term();
      if (p_bad) begin
         r = '{total: '0, malformed: 1'b1, saturated: 1'b0};
      end else begin
         r = '{total: p_total[MS_W-1:0], malformed: 1'b0, saturated: p_sat};
      end
      expected_totals.push_back(r);
      predictor_clear();
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
   endtask

   // Sends one byte as a beat, idling beforehand at the current rate. The
   // payload is set at the falling edge and held until the beat is taken.
   // Valid stays high afterwards so that beats can follow back to back; it
   // drops in the idle loop or when the sender waits for results.
   task automatic send_byte(logic [7:0] c, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      predict_byte(c, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
      texts_sent++;
   endtask

   // Holds the sender off until every predicted result has come back.
   task automatic wait_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_totals.size() != 0);
   endtask

   // Waits until every predicted result has come back.
   task automatic drain_results();
      wait_results();
      repeat (8) @(negedge clock);
   endtask

   // Result checker: compares each result beat with the oldest prediction.
   always @(posedge clock) begin
      duration_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_totals.size() == 0) begin
            report_mismatch("unexpected result, total", 64'(rsp_total_ms), 0);
         end else begin
            want = expected_totals.pop_front();
            if (rsp_total_ms !== want.total)
               report_mismatch("total_ms", 64'(rsp_total_ms), 64'(want.total));
            if (rsp_malformed !== want.malformed)
               report_mismatch("malformed", 64'(rsp_malformed), 64'(want.malformed));
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", 64'(rsp_saturated), 64'(want.saturated));
         end
      end
   end

   // Receiver stall, redrawn at every falling edge.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // ---- Test tasks ----

   // Directed texts: each unit spelling, case mixing, fractions, the lone
   // dot, the second dot, huge numbers, long units and stray bytes.
   task automatic test_directed();
      string texts[$];
      texts = '{"1h20m30s", "1.5h", "250ms", "7", "3SEC", "2Min", "1hr", "1HOUR",
                "2d", "1day", "1w", "1WK", "1week", "1mo", "1mon", "1month",
                "1y", "1yr", "1year", ".", "1.5.5", "0.1234567891y",
                "99999999999999999999999y", " \t1 s\n2m", "5months", "3x 4s",
                "1s#9h", "2305843009213693951ms 1s", "", "\xff\x00"};
      foreach (texts[k]) begin
         if (texts[k].len() == 0) send_byte(" ", 1'b1);
         else send_text(texts[k]);
      end
      send_byte(8'h80, 1'b1);
      drain_results();
   endtask

   // Builds one random text: mostly well-formed terms, some noise.
   function automatic string random_text();
      string units[$];
      string s, num, u;
      int terms;
      units = '{"ms", "s", "sec", "", "m", "min", "h", "hr", "hour", "d", "day",
                "w", "wk", "week", "mo", "mon", "month", "y", "yr", "year",
                "q", "hours", "xyzzyq", "Ms", "YEAR"};
      s = "";
      terms = $urandom_range(1, 3);
      for (int t = 0; t < terms; t++) begin
         if ($urandom_range(3) == 0) s = {s, " "};
         num = "";
         repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 22 : 3))
            num = {num, string'(8'("0") + 8'($urandom_range(9)))};
         if ($urandom_range(2) == 0) begin
            num = {num, "."};
            repeat ($urandom_range(0, 9))
               num = {num, string'(8'("0") + 8'($urandom_range(9)))};
         end
         if ($urandom_range(19) == 0) num = ".";
         u = units[$urandom_range(units.size() - 1)];
         for (int k = 0; k < u.len(); k++)
            if ($urandom_range(1)) u[k] = u[k] ^ 8'h20;
         s = {s, num, u};
      end
      if ($urandom_range(7) == 0) s = {s, string'(8'($urandom_range(255)))};
      return s;
   endfunction

   // Random texts under one idling pattern, until the byte budget is used.
   task automatic test_random_phase(int unsigned send_pct, int unsigned recv_pct,
                                    int byte_budget);
      int goal;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      goal = bytes_sent + byte_budget;
      while (bytes_sent < goal) begin
         send_text(random_text());
         // Now and then the sender holds off until all results are back.
         if ($urandom_range(15) == 0) wait_results();
      end
      drain_results();
   endtask

   // Random raw bytes of any value, so that the input bits are driven to both values.
   task automatic test_random_bytes();
      repeat (60) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      send_byte("1", 1'b1);
      drain_results();
   endtask

   initial begin
      predictor_clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(0, 0, 130);
      test_random_phase(59, 0, 110);
      test_random_phase(0, 59, 110);
      test_random_phase(9, 9, 110);
      test_random_bytes();
      repeat (200) @(negedge clock);
      $display("Covered %0d texts in %0d bytes and %0d results, all unit spellings,",
               texts_sent, bytes_sent, results_seen);
      $display("fractions, lone dots, saturation and random idling on both sides.");
      if (mismatch_count == 0 && expected_totals.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
